>>> src/rmip_pkg.sv
// ----------------------------------------------------------------------------
// rmip_pkg
// Shared types and constants for the random match index picker.
// ----------------------------------------------------------------------------
`default_nettype none

package rmip_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH     = 1024;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int IDX_W     = 10;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int DIV_STEPS = DATA_W;
    localparam int DSTEP_W   = $clog2(DIV_STEPS);

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_PICK   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOMATCH = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic signed [DATA_W-1:0] value;
        logic [DATA_W-1:0]        random_word;
    } t_in_item;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] picked_index;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

>>> src/rmip_store.sv
// ----------------------------------------------------------------------------
// rmip_store
// Element memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rmip_store (
    input  wire                      i_clk,
    input  rmip_pkg::t_mem_req       i_req,
    output logic [rmip_pkg::DATA_W-1:0] o_rdata
);
    import rmip_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

`default_nettype wire

>>> src/rmip_div.sv
// ----------------------------------------------------------------------------
// rmip_div
// Bit-serial restoring remainder unit: dividend mod match count.
// ----------------------------------------------------------------------------
`default_nettype none

module rmip_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire  [rmip_pkg::DATA_W-1:0]  i_dividend,
    input  wire  [rmip_pkg::CNT_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [rmip_pkg::CNT_W-1:0]   o_rem
);
    import rmip_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [DSTEP_W-1:0] r_step;
    logic [DATA_W-1:0]  r_dvd;
    logic [CNT_W-1:0]   r_dsr;
    logic [CNT_W-1:0]   r_rem;
    logic [CNT_W:0]     w_trial;
    logic [CNT_W:0]     w_diff;
    logic               w_ge;

    // partial remainder stays below the divisor, so the trial fits CNT_W+1 bits
    assign w_trial = {r_rem, r_dvd[DATA_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == DSTEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DATA_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

>>> src/random_match_index_picker_top.sv
// ----------------------------------------------------------------------------
// random_match_index_picker_top
// Stores appended values and picks a random position among those equal
// to a target.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------
//  in      | input     | i_in_valid / o_in_ready  | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready| o_out_data (t_out_item)
//
//  clear, append and unused opcodes pass from transfer through S_RESP into
//  the output register. a pick makes two passes over the element memory at
//  one read per cycle, with a 32-step remainder unit between the passes.
//  one item is in work at a time; the next item is taken once the result
//  sits in the output register, even while that result is stalled.
//  reset (synchronous, active low) empties the array; memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module random_match_index_picker_top (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  rmip_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output rmip_pkg::t_out_item  o_out_data
);
    import rmip_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CNT  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [2:0]        r_state,    n_state;
    logic [CNT_W-1:0]  r_fill,     n_fill;
    logic [DATA_W-1:0] r_target,   n_target;
    logic [DATA_W-1:0] r_rnd,      n_rnd;
    logic [CNT_W-1:0]  r_issue,    n_issue;
    logic              r_pend,     n_pend;
    logic [ADDR_W-1:0] r_data_idx, n_data_idx;
    logic [CNT_W-1:0]  r_cnt,      n_cnt;
    logic [CNT_W-1:0]  r_want,     n_want;
    t_out_item         r_res,      n_res;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out,      n_out;

    t_mem_req          w_req;
    logic [DATA_W-1:0] w_rdata;
    logic              w_accept;
    logic              w_hit;
    logic              w_div_start;
    logic              w_div_done;
    logic [CNT_W-1:0]  w_div_rem;

    rmip_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    rmip_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_rnd),
        .i_divisor  (r_cnt),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_hit      = r_pend && (w_rdata == r_target);

    // append writes at transfer; a later pick reads only from S_CNT on, after the write
    always_comb begin
        w_req.we    = w_accept && (i_in_data.opcode == OP_APPEND) &&
                      (r_fill < CNT_W'(DEPTH));
        w_req.waddr = r_fill[ADDR_W-1:0];
        w_req.wdata = i_in_data.value;
        w_req.raddr = r_issue[ADDR_W-1:0];
    end

    assign w_div_start = (r_state == S_CNT) && (r_issue == r_fill) && !r_pend &&
                         (r_cnt != '0);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_target    = r_target;
        n_rnd       = r_rnd;
        n_issue     = r_issue;
        n_pend      = 1'b0;
        n_data_idx  = r_data_idx;
        n_cnt       = r_cnt;
        n_want      = r_want;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        // one read per cycle during both passes
        if ((r_state == S_CNT) || (r_state == S_SCAN)) begin
            if (r_issue != r_fill) begin
                n_issue    = r_issue + 1'b1;
                n_pend     = 1'b1;
                n_data_idx = r_issue[ADDR_W-1:0];
            end
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res.status       = ST_OK;
                    n_res.picked_index = '0;
                    n_state            = S_RESP;
                    case (i_in_data.opcode)
                        OP_CLEAR: begin
                            n_fill = '0;
                        end
                        OP_APPEND: begin
                            if (r_fill < CNT_W'(DEPTH)) begin
                                n_fill = r_fill + 1'b1;
                            end else begin
                                n_res.status = ST_FULL;
                            end
                        end
                        OP_PICK: begin
                            n_target = i_in_data.value;
                            n_rnd    = i_in_data.random_word;
                            n_issue  = '0;
                            n_cnt    = '0;
                            if (r_fill == '0) begin
                                n_res.status = ST_NOMATCH;
                            end else begin
                                n_state = S_CNT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CNT: begin
                if (w_hit) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if ((r_issue == r_fill) && !r_pend) begin
                    if (r_cnt == '0) begin
                        n_res.status       = ST_NOMATCH;
                        n_res.picked_index = '0;
                        n_state            = S_RESP;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_want  = w_div_rem;
                    n_issue = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    if (r_want == '0) begin
                        n_res.status       = ST_OK;
                        n_res.picked_index = IDX_W'(r_data_idx);
                        n_state            = S_RESP;
                    end else begin
                        n_want = r_want - 1'b1;
                    end
                end else if ((r_issue == r_fill) && !r_pend) begin
                    n_res.status       = ST_NOMATCH;
                    n_res.picked_index = '0;
                    n_state            = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target   <= n_target;
        r_rnd      <= n_rnd;
        r_issue    <= n_issue;
        r_data_idx <= n_data_idx;
        r_cnt      <= n_cnt;
        r_want     <= n_want;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> src/rmip_checker.sv
// ----------------------------------------------------------------------------
// rmip_checker
// Port-level checks for the random match index picker, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rmip_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  o_in_ready,
    input  wire                  o_out_valid,
    input  wire                  i_out_ready,
    input  rmip_pkg::t_out_item  o_out_data
);
    import rmip_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // only a successful pick carries a nonzero index
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |-> o_out_data.picked_index == '0)
        else $error("nonzero index on a failed item");

    // one item in work at a time: no transfer right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in work");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind random_match_index_picker_top rmip_checker u_rmip_checker (.*);

`default_nettype wire
